[sv/ptts_pkg.sv]
// Package with the shared types and codes of the periodic task tick scheduler.
`timescale 1ns / 1ps

package ptts_pkg;

    // Item kinds carried on the input channel.
    typedef enum logic [2:0] {
        K_TICK    = 3'd0,
        K_CREATE  = 3'd1,
        K_DELETE  = 3'd2,
        K_SUSPEND = 3'd3,
        K_RESUME  = 3'd4,
        K_QUERY   = 3'd5
    } t_kind;

    // Slot status codes.
    typedef enum logic [1:0] {
        ST_EMPTY   = 2'd0,
        ST_READY   = 2'd1,
        ST_SUSP    = 2'd2,
        ST_DELETED = 2'd3
    } t_status;

    localparam int unsigned ID_W    = 3;
    localparam int unsigned TIME_W  = 8;
    localparam int unsigned MASK_W  = 8;

    // One memory entry: period and countdown of a slot.
    typedef struct packed {
        logic [TIME_W-1:0] period;
        logic [TIME_W-1:0] countdown;
    } t_slot_entry;

endpackage

[sv/ptts_slot_mem.sv]
// Timing memory of the scheduler: one write port and one registered read port.
`timescale 1ns / 1ps

module ptts_slot_mem
    import ptts_pkg::*;
#(
    parameter int unsigned DEPTH = 8,
    parameter int unsigned AW    = 3
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  t_slot_entry       i_wdata,
    input  logic [AW-1:0]     i_raddr,
    output t_slot_entry       o_rdata
);

    t_slot_entry r_mem [DEPTH];
    t_slot_entry r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/periodic_task_tick_scheduler_core.sv]
// Top level of the periodic task tick scheduler: control sequencer and slot status.
`timescale 1ns / 1ps
// A command item passes from acceptance through S_CMD and S_RESULT to the output register;
// the next item can be accepted once the sequencer is back in S_IDLE. A tick item walks
// the slots in S_TICK, then passes through S_DRAIN and S_RESULT to the output register:
// the walk reads one slot per cycle and writes it back in the cycle after the read.
// A stalled result held in the output register delays the load of the next result.
// Synchronous active-low reset marks every slot empty and empties the output register.

module periodic_task_tick_scheduler_core
    import ptts_pkg::*;
#(
    parameter int unsigned NUM_TASKS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [2:0]        i_in_kind,
    input  logic [ID_W-1:0]   i_in_task_id,
    input  logic [TIME_W-1:0] i_in_period,
    input  logic [TIME_W-1:0] i_in_initial_delay,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [MASK_W-1:0] o_out_fired_mask,
    output logic [1:0]        o_out_slot_state
);

    localparam int unsigned IW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TICK,
        S_DRAIN,
        S_CMD,
        S_RESULT
    } t_state;

    t_state             r_state;
    logic [2:0]         r_kind;
    logic [ID_W-1:0]    r_id;
    logic               r_id_ok;
    logic [TIME_W-1:0]  r_period;
    logic [TIME_W-1:0]  r_delay;
    logic [IW-1:0]      r_idx;
    logic               r_pend;
    logic [IW-1:0]      r_pidx;
    logic [MASK_W-1:0]  r_mask;
    logic               r_o_valid;
    logic [MASK_W-1:0]  r_o_mask;
    logic [1:0]         r_o_state;
    t_status            r_status [NUM_TASKS];

    logic               in_acc;
    logic               out_free;
    logic [IW-1:0]      id_idx;
    logic [IW-1:0]      st_addr;
    t_status            st_rd;
    logic               mem_we;
    logic [IW-1:0]      mem_waddr;
    t_slot_entry        mem_wdata;
    t_slot_entry        mem_rdata;
    logic               fire;
    logic               st_we;
    t_status            st_wdata;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign out_free   = !r_o_valid || !i_out_stall;
    assign id_idx     = IW'(r_id);

    // Status read: the slot being written back during a walk, else the addressed slot.
    assign st_addr = r_pend ? r_pidx : id_idx;
    assign st_rd   = r_status[st_addr];

    // The pending slot fires when it is ready and its countdown has run out.
    assign fire = (st_rd == ST_READY) && (mem_rdata.countdown == '0);

    // Timing memory write: tick write-back or create.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_pidx;
        mem_wdata = mem_rdata;
        if (r_pend) begin
            mem_we = (st_rd == ST_READY);
            if (fire) begin
                mem_wdata.countdown = (mem_rdata.period == '0) ? '0
                                      : mem_rdata.period - TIME_W'(1);
            end else begin
                mem_wdata.countdown = mem_rdata.countdown - TIME_W'(1);
            end
        end else if (r_state == S_CMD && r_id_ok && r_kind == K_CREATE) begin
            mem_we              = 1'b1;
            mem_waddr           = id_idx;
            mem_wdata.period    = r_period;
            mem_wdata.countdown = r_delay;
        end
    end

    // Status update for commands.
    always_comb begin
        st_we    = 1'b0;
        st_wdata = st_rd;
        if (r_state == S_CMD && r_id_ok) begin
            unique case (r_kind)
                K_CREATE: begin
                    st_we    = 1'b1;
                    st_wdata = ST_READY;
                end
                K_DELETE: begin
                    st_we    = 1'b1;
                    st_wdata = ST_DELETED;
                end
                K_SUSPEND: begin
                    st_we    = 1'b1;
                    st_wdata = ST_SUSP;
                end
                K_RESUME: begin
                    st_we    = (st_rd != ST_EMPTY);
                    st_wdata = ST_READY;
                end
                default: begin
                    st_we = 1'b0;
                end
            endcase
        end
    end

    // Slot status flops, cleared to empty by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_TASKS; i++) begin
                r_status[i] <= ST_EMPTY;
            end
        end else if (st_we) begin
            r_status[id_idx] <= st_wdata;
        end
    end

    ptts_slot_mem #(
        .DEPTH (NUM_TASKS),
        .AW    (IW)
    ) u_slot_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_idx),
        .o_rdata (mem_rdata)
    );

    // Sequencer, tick walk and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pend    <= 1'b0;
            r_o_valid <= 1'b0;
            r_idx     <= '0;
        end else begin
            // Load the finished result, or empty the output register once it is taken.
            if (r_state == S_RESULT && out_free) begin
                r_o_valid <= 1'b1;
                r_o_mask  <= r_mask;
                r_o_state <= r_id_ok ? st_rd : ST_EMPTY;
            end else if (r_o_valid && !i_out_stall) begin
                r_o_valid <= 1'b0;
            end
            if (r_pend && fire) begin
                r_mask <= r_mask | (MASK_W'(1) << r_pidx);
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_kind   <= i_in_kind;
                        r_id     <= i_in_task_id;
                        r_id_ok  <= (32'(i_in_task_id) < NUM_TASKS);
                        r_period <= i_in_period;
                        r_delay  <= i_in_initial_delay;
                        r_mask   <= '0;
                        r_idx    <= '0;
                        r_state  <= (i_in_kind == K_TICK) ? S_TICK : S_CMD;
                    end
                end
                S_TICK: begin
                    // Read slot r_idx now; it is written back next cycle.
                    r_pend <= 1'b1;
                    r_pidx <= r_idx;
                    if (r_idx == IW'(NUM_TASKS - 1)) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_idx <= r_idx + IW'(1);
                    end
                end
                S_DRAIN: begin
                    r_pend  <= 1'b0;
                    r_state <= S_RESULT;
                end
                S_CMD: begin
                    r_state <= S_RESULT;
                end
                S_RESULT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid      = r_o_valid;
    assign o_out_fired_mask = r_o_mask;
    assign o_out_slot_state = r_o_state;

    // No write-back may be pending outside the tick walk.
    a_pend_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_state == S_TICK || r_state == S_DRAIN))
        else $error("write-back pending outside the tick walk");

    // The timing memory is never written while the sequencer is idle.
    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !mem_we)
        else $error("timing memory written while idle");

    // A command item never reports fired slots.
    a_cmd_no_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESULT && r_kind != K_TICK) |-> (r_mask == '0))
        else $error("fired mask set for a command item");

    // Slots beyond the table never fire.
    a_mask_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((32'(o_out_fired_mask) >> NUM_TASKS) == 32'd0))
        else $error("fired mask has a bit beyond the table");

endmodule
